FILE: hdl/fkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad calculator package
// Key codes, the command word passed from the front end to the execution
// unit, and the grid and arithmetic constants.
// ----------------------------------------------------------------------------
package fkc_pkg;

   localparam int unsigned GRID_LIMIT      = 87;
   localparam int unsigned KEY_PITCH       = 22;
   localparam int unsigned RADIX           = 10;
   localparam int unsigned ROW0_DIGIT_BASE = 7;
   localparam int unsigned ROW1_DIGIT_BASE = 4;
   localparam int unsigned ROW2_DIGIT_BASE = 1;

   localparam int unsigned OPERAND_WIDTH = 64;
   localparam int unsigned HALF_WIDTH    = OPERAND_WIDTH / 2;
   localparam int unsigned DIV_CNT_WIDTH = $clog2(OPERAND_WIDTH);

   localparam int unsigned CMD_QUEUE_DEPTH = 4;
   localparam int unsigned CMD_PTR_WIDTH   = $clog2(CMD_QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KEY_DIGIT  = 2'd0,
      KEY_OPER   = 2'd1,
      KEY_EQUALS = 2'd2,
      KEY_CLEAR  = 2'd3
   } key_type;

   typedef struct packed {
      key_type    kind;
      logic [3:0] value;
   } cmd_type;

endpackage

`default_nettype wire

FILE: hdl/fkc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad front end
// Takes click words, drops clicks outside the key grid, resolves the key
// and pushes a command word into the command queue.
// ----------------------------------------------------------------------------
module fkc_front (
   input  wire logic             push,
   output logic                  full,
   input  wire logic [7:0]       click_col,
   input  wire logic [7:0]       click_row,
   input  wire logic             q_full,
   output logic                  q_wr,
   output fkc_pkg::cmd_type      q_data
);

   function automatic logic [1:0] pitch_index(input logic [7:0] pos);
      logic [1:0] idx;
      if (pos >= 8'(3 * fkc_pkg::KEY_PITCH)) begin
         idx = 2'd3;
      end else if (pos >= 8'(2 * fkc_pkg::KEY_PITCH)) begin
         idx = 2'd2;
      end else if (pos >= 8'(fkc_pkg::KEY_PITCH)) begin
         idx = 2'd1;
      end else begin
         idx = 2'd0;
      end
      return idx;
   endfunction

   logic       in_grid;
   logic [1:0] col;
   logic [1:0] row;
   logic [3:0] digit;

   assign in_grid = (click_col <= 8'(fkc_pkg::GRID_LIMIT)) &&
                    (click_row <= 8'(fkc_pkg::GRID_LIMIT));
   assign col     = pitch_index(click_col);
   assign row     = pitch_index(click_row);
   assign full    = q_full;
   assign q_wr    = push && !q_full && in_grid;

   always_comb begin
      case (row)
         2'd0:    digit = 4'(fkc_pkg::ROW0_DIGIT_BASE) + {2'b00, col};
         2'd1:    digit = 4'(fkc_pkg::ROW1_DIGIT_BASE) + {2'b00, col};
         2'd2:    digit = 4'(fkc_pkg::ROW2_DIGIT_BASE) + {2'b00, col};
         default: digit = 4'd0;
      endcase
   end

   always_comb begin
      q_data.kind  = fkc_pkg::KEY_DIGIT;
      q_data.value = digit;
      if (col == 2'd3) begin
         q_data.kind  = fkc_pkg::KEY_OPER;
         q_data.value = {2'b00, row};
      end else if (row == 2'd3 && col == 2'd2) begin
         q_data.kind = fkc_pkg::KEY_EQUALS;
      end else if (row == 2'd3 && col == 2'd1) begin
         q_data.kind = fkc_pkg::KEY_CLEAR;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/fkc_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer of command words between the front end
// and the execution unit.
// ----------------------------------------------------------------------------
module fkc_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire fkc_pkg::cmd_type  wr_data,
   output logic                   wr_full,
   output logic                   rd_valid,
   input  wire logic              rd_pop,
   output fkc_pkg::cmd_type       rd_data
);

   localparam int unsigned PW = fkc_pkg::CMD_PTR_WIDTH;

   fkc_pkg::cmd_type slot_ff [fkc_pkg::CMD_QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_full  = (count_ff == (PW + 1)'(fkc_pkg::CMD_QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !wr_full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/fkc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Execution unit
// Holds the operands and pending operator, carries out command words and
// keeps the result word register. Multiply runs as three 32x32 partial
// products; divide runs bit-serially over magnitudes.
// ----------------------------------------------------------------------------
module fkc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire fkc_pkg::cmd_type  cmd_data,
   output logic                   cmd_pop,
   output logic                   empty,
   input  wire logic              pop,
   output logic signed [63:0]     display_value,
   output logic                   divide_error
);

   localparam int unsigned W  = fkc_pkg::OPERAND_WIDTH;
   localparam int unsigned HW = fkc_pkg::HALF_WIDTH;
   localparam int unsigned CW = fkc_pkg::DIV_CNT_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_DIV_FIX
   } state_type;

   state_type        state_ff, state_in;
   logic             second_ff, second_in;
   fkc_pkg::op_type  oper_ff, oper_in;
   logic [W-1:0]     x_ff, x_in;
   logic [W-1:0]     y_ff, y_in;
   logic [W-1:0]     work_a_ff, work_a_in;
   logic [W-1:0]     work_b_ff, work_b_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [HW-1:0]    cross_ff, cross_in;
   logic [1:0]       mul_step_ff, mul_step_in;
   logic [CW-1:0]    div_cnt_ff, div_cnt_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]     rsp_value_ff, rsp_value_in;
   logic             rsp_err_ff, rsp_err_in;

   logic             slot_free;
   logic [W-1:0]     cur_operand;
   logic [W-1:0]     next_operand;
   logic [HW-1:0]    mul_a, mul_b;
   logic [W-1:0]     mul_prod;
   logic [W:0]       div_shift;
   logic [W:0]       div_diff;
   logic [W-1:0]     abs_x, abs_y;

   assign empty         = !rsp_valid_ff;
   assign display_value = rsp_value_ff;
   assign divide_error  = rsp_err_ff;
   assign slot_free     = !rsp_valid_ff || pop;

   assign cur_operand  = second_ff ? y_ff : x_ff;
   assign next_operand = (cur_operand << 3) + (cur_operand << 1) +
                         W'(cmd_data.value);

   assign abs_x = x_ff[W-1] ? W'(0) - x_ff : x_ff;
   assign abs_y = y_ff[W-1] ? W'(0) - y_ff : y_ff;

   always_comb begin
      case (mul_step_ff)
         2'd0: begin
            mul_a = work_a_ff[HW-1:0];
            mul_b = work_b_ff[HW-1:0];
         end
         2'd1: begin
            mul_a = work_a_ff[HW-1:0];
            mul_b = work_b_ff[W-1:HW];
         end
         default: begin
            mul_a = work_a_ff[W-1:HW];
            mul_b = work_b_ff[HW-1:0];
         end
      endcase
   end

   assign mul_prod  = W'(mul_a) * W'(mul_b);
   assign div_shift = {acc_ff, work_a_ff[W-1]};
   assign div_diff  = div_shift - {1'b0, work_b_ff};

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      oper_in      = oper_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      work_a_in    = work_a_ff;
      work_b_in    = work_b_ff;
      acc_in       = acc_ff;
      cross_in     = cross_ff;
      mul_step_in  = mul_step_ff;
      div_cnt_in   = div_cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      cmd_pop      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               case (cmd_data.kind)
                  fkc_pkg::KEY_OPER: begin
                     oper_in   = fkc_pkg::op_type'(cmd_data.value[1:0]);
                     second_in = 1'b1;
                  end
                  fkc_pkg::KEY_CLEAR: begin
                     second_in    = 1'b0;
                     x_in         = '0;
                     y_in         = '0;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_err_in   = 1'b0;
                  end
                  fkc_pkg::KEY_DIGIT: begin
                     if (second_ff) begin
                        y_in = next_operand;
                     end else begin
                        x_in = next_operand;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_value_in = next_operand;
                     rsp_err_in   = 1'b0;
                  end
                  default: begin
                     second_in = 1'b0;
                     y_in      = '0;
                     case (oper_ff)
                        fkc_pkg::OP_ADD: begin
                           x_in         = x_ff + y_ff;
                           rsp_valid_in = 1'b1;
                           rsp_value_in = x_ff + y_ff;
                           rsp_err_in   = 1'b0;
                        end
                        fkc_pkg::OP_SUB: begin
                           x_in         = x_ff - y_ff;
                           rsp_valid_in = 1'b1;
                           rsp_value_in = x_ff - y_ff;
                           rsp_err_in   = 1'b0;
                        end
                        fkc_pkg::OP_MUL: begin
                           work_a_in   = x_ff;
                           work_b_in   = y_ff;
                           mul_step_in = 2'd0;
                           state_in    = S_MUL;
                        end
                        default: begin
                           if (y_ff == '0) begin
                              rsp_valid_in = 1'b1;
                              rsp_value_in = x_ff;
                              rsp_err_in   = 1'b1;
                           end else begin
                              work_a_in  = abs_x;
                              work_b_in  = abs_y;
                              acc_in     = '0;
                              neg_in     = x_ff[W-1] ^ y_ff[W-1];
                              div_cnt_in = '1;
                              state_in   = S_DIV;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end
         S_MUL: begin
            mul_step_in = mul_step_ff + 1'b1;
            case (mul_step_ff)
               2'd0:    acc_in   = mul_prod;
               2'd1:    cross_in = mul_prod[HW-1:0];
               default: begin
                  x_in         = acc_ff + {cross_ff + mul_prod[HW-1:0], HW'(0)};
                  rsp_valid_in = 1'b1;
                  rsp_value_in = acc_ff + {cross_ff + mul_prod[HW-1:0], HW'(0)};
                  rsp_err_in   = 1'b0;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            acc_in     = div_diff[W] ? div_shift[W-1:0] : div_diff[W-1:0];
            work_a_in  = {work_a_ff[W-2:0], ~div_diff[W]};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = S_DIV_FIX;
            end
         end
         default: begin
            x_in         = neg_ff ? W'(0) - work_a_ff : work_a_ff;
            rsp_valid_in = 1'b1;
            rsp_value_in = neg_ff ? W'(0) - work_a_ff : work_a_ff;
            rsp_err_in   = 1'b0;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         second_ff    <= 1'b0;
         oper_ff      <= fkc_pkg::OP_ADD;
         x_ff         <= '0;
         y_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         oper_ff      <= oper_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_a_ff    <= work_a_in;
      work_b_ff    <= work_b_in;
      acc_ff       <= acc_in;
      cross_ff     <= cross_in;
      mul_step_ff  <= mul_step_in;
      div_cnt_ff   <= div_cnt_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

endmodule

`default_nettype wire

FILE: hdl/four_function_keypad_calculator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-function keypad calculator
// Click positions on a 4x4 key grid in, display words out, both sides
// queue-like.
// ----------------------------------------------------------------------------
// Each click word names a pixel position in a 4x4 grid of 22-pixel keys;
// clicks beyond 87 on either axis are dropped without a result, as are
// operator keys, which only select the pending operation. The front end
// classifies a click combinationally and queues a command (four deep), so
// push is taken while earlier keys are still executing. Digit, clear, add
// and subtract keys execute straight from the idle state; multiply steps
// one shared 32x32 multiplier through three partial products, and divide
// runs a one-bit-per-cycle divider over the magnitudes, then fixes the
// sign; a result then waits in the output register until popped. Division
// by zero keeps the first operand and raises divide_error on that result.
module four_function_keypad_calculator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [7:0]         req_click_col_offset,
   input  wire logic [7:0]         req_click_row_offset,
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [63:0]      rsp_display_value,
   output logic                    rsp_divide_error
);

   logic              q_wr;
   fkc_pkg::cmd_type  q_wr_data;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   fkc_pkg::cmd_type  q_rd_data;

   fkc_front u_front (
      .push      (push),
      .full      (full),
      .click_col (req_click_col_offset),
      .click_row (req_click_row_offset),
      .q_full    (q_full),
      .q_wr      (q_wr),
      .q_data    (q_wr_data)
   );

   fkc_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_data  (q_wr_data),
      .wr_full  (q_full),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  (q_rd_data)
   );

   fkc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_data      (q_rd_data),
      .cmd_pop       (q_pop),
      .empty         (empty),
      .pop           (pop),
      .display_value (rsp_display_value),
      .divide_error  (rsp_divide_error)
   );

endmodule

`default_nettype wire

FILE: sim/four_function_keypad_calculator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad calculator testbench
// Sends click words onto the 4x4 key grid: a short directed run over the grid
// edges, every key and every operator, then random key sequences with noise
// between them under several idling patterns. An in-bench model of the
// calculator predicts each display word, and the scoreboard checks it against
// the words that the block returns.
// ----------------------------------------------------------------------------
module four_function_keypad_calculator_test;

   localparam int unsigned CLOCK_HALF    = 5;
   localparam int unsigned CLICK_TARGET  = 1950;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam int unsigned OPER_COL      = 3;
   localparam int unsigned CLEAR_COL     = 1;
   localparam int unsigned EQUALS_COL    = 2;
   localparam int unsigned BOTTOM_ROW    = 3;
   localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MINUS_ONE     = 64'hFFFF_FFFF_FFFF_FFFF;

   class calc_scoreboard;
      bit               second_entry;
      fkc_pkg::op_type  pending_op;
      bit [63:0]        first_val;
      bit [63:0]        second_val;
      bit [63:0]        value_q[$];
      bit               error_q[$];
      int unsigned      grid_clicks;
      int unsigned      errors;

      function new();
         pending_op = fkc_pkg::OP_ADD;
      endfunction

      function void note_click(bit [7:0] cx, bit [7:0] cy);
         int unsigned col;
         int unsigned row;
         bit [63:0]   digit;
         bit [63:0]   mag_a;
         bit [63:0]   mag_b;
         bit [63:0]   quot;
         bit          div_error;
         if (cx > fkc_pkg::GRID_LIMIT || cy > fkc_pkg::GRID_LIMIT)
            return;
         grid_clicks++;
         col = cx / fkc_pkg::KEY_PITCH;
         row = cy / fkc_pkg::KEY_PITCH;
         div_error = 1'b0;
         if (col == OPER_COL) begin
            pending_op = fkc_pkg::op_type'(row[1:0]);
            second_entry = 1'b1;
            return;
         end
         if (row == BOTTOM_ROW && col == EQUALS_COL) begin
            case (pending_op)
               fkc_pkg::OP_ADD: first_val = first_val + second_val;
               fkc_pkg::OP_SUB: first_val = first_val - second_val;
               fkc_pkg::OP_MUL: first_val = first_val * second_val;
               default: begin
                  if (second_val == 64'd0) begin
                     div_error = 1'b1;
                  end else begin
                     // truncate toward zero on magnitudes, then restore sign
                     mag_a = first_val[63] ? -first_val : first_val;
                     mag_b = second_val[63] ? -second_val : second_val;
                     quot = mag_a / mag_b;
                     first_val = (first_val[63] != second_val[63]) ? -quot : quot;
                  end
               end
            endcase
            second_entry = 1'b0;
            second_val = 64'd0;
            value_q.push_back(first_val);
         end else if (row == BOTTOM_ROW && col == CLEAR_COL) begin
            second_entry = 1'b0;
            first_val = 64'd0;
            second_val = 64'd0;
            value_q.push_back(64'd0);
         end else begin
            case (row)
               0: digit = col + fkc_pkg::ROW0_DIGIT_BASE;
               1: digit = col + fkc_pkg::ROW1_DIGIT_BASE;
               2: digit = col + fkc_pkg::ROW2_DIGIT_BASE;
               default: digit = 64'd0;
            endcase
            if (second_entry) begin
               second_val = second_val * fkc_pkg::RADIX + digit;
               value_q.push_back(second_val);
            end else begin
               first_val = first_val * fkc_pkg::RADIX + digit;
               value_q.push_back(first_val);
            end
         end
         error_q.push_back(div_error);
      endfunction

      task report(string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [63:0] value, logic div_error);
         bit [63:0] want_value;
         bit        want_error;
         if (value_q.size() == 0) begin
            report($sformatf("display word %0d with nothing expected", $signed(value)));
            return;
         end
         want_value = value_q.pop_front();
         want_error = error_q.pop_front();
         if (value !== want_value)
            report($sformatf("display_value %0d, expected %0d",
                             $signed(value), $signed(want_value)));
         if (div_error !== want_error)
            report($sformatf("divide_error %b, expected %b", div_error, want_error));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [7:0]        req_click_col_offset = 8'd0;
   logic [7:0]        req_click_row_offset = 8'd0;
   logic              empty;
   logic              pop = 1'b0;
   logic signed [63:0] rsp_display_value;
   logic              rsp_divide_error;

   int unsigned       sender_idle_pct = 0;
   int unsigned       receiver_stall_pct = 0;
   int unsigned       stalled_cycles = 0;
   calc_scoreboard    sb = new();

   four_function_keypad_calculator uut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_click_col_offset (req_click_col_offset),
      .req_click_row_offset (req_click_row_offset),
      .empty                (empty),
      .pop                  (pop),
      .rsp_display_value    (rsp_display_value),
      .rsp_divide_error     (rsp_divide_error)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            sb.note_click(req_click_col_offset, req_click_row_offset);
         if (pop && !empty)
            sb.check_result(rsp_display_value, rsp_divide_error);
         if ((push && !full) || (pop && !empty)) begin
            stalled_cycles <= 0;
         end else if (stalled_cycles == STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            stalled_cycles <= stalled_cycles + 1;
         end
      end
   end

   // hold push high across back-to-back words; drop it only when idling
   task automatic send_click(input int unsigned cx, input int unsigned cy);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_click_col_offset <= cx[7:0];
      req_click_row_offset <= cy[7:0];
      do @(posedge clock); while (full);
   endtask

   task automatic press_key(input int unsigned col, input int unsigned row);
      send_click(col * fkc_pkg::KEY_PITCH + $urandom_range(0, fkc_pkg::KEY_PITCH - 1),
                 row * fkc_pkg::KEY_PITCH + $urandom_range(0, fkc_pkg::KEY_PITCH - 1));
   endtask

   task automatic press_digit(input int unsigned d);
      if (d == 0)
         press_key(0, BOTTOM_ROW);
      else if (d < fkc_pkg::ROW1_DIGIT_BASE)
         press_key(d - fkc_pkg::ROW2_DIGIT_BASE, 2);
      else if (d < fkc_pkg::ROW0_DIGIT_BASE)
         press_key(d - fkc_pkg::ROW1_DIGIT_BASE, 1);
      else
         press_key(d - fkc_pkg::ROW0_DIGIT_BASE, 0);
   endtask

   task automatic press_op(input fkc_pkg::op_type op);
      press_key(OPER_COL, op);
   endtask

   task automatic press_equals();
      press_key(EQUALS_COL, BOTTOM_ROW);
   endtask

   task automatic press_clear();
      press_key(CLEAR_COL, BOTTOM_ROW);
   endtask

   task automatic type_value(input bit [63:0] v);
      bit [63:0]   rest;
      int unsigned digits[$];
      rest = v;
      do begin
         digits.push_front(32'(rest % fkc_pkg::RADIX));
         rest = rest / fkc_pkg::RADIX;
      end while (rest != 0);
      foreach (digits[i])
         press_digit(digits[i]);
   endtask

   task automatic enter_operand();
      int unsigned form;
      form = $urandom_range(0, 99);
      if (form < 12)
         return;
      if (form < 65) begin
         type_value(64'($urandom_range(0, 9999)));
      end else if (form < 87) begin
         type_value({$urandom, $urandom} >> $urandom_range(0, 63));
      end else begin
         case ($urandom_range(0, 4))
            0: type_value(MOST_NEGATIVE);
            1: type_value(MOST_POSITIVE);
            2: type_value(MINUS_ONE);
            3: type_value(64'd1);
            default: type_value(64'd0);
         endcase
      end
   endtask

   task automatic run_sequence();
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 6))
            send_click($urandom_range(0, 1) ? $urandom_range(0, fkc_pkg::GRID_LIMIT)
                                           : $urandom_range(0, 255),
                       $urandom_range(0, 1) ? $urandom_range(0, fkc_pkg::GRID_LIMIT)
                                           : $urandom_range(0, 255));
      end else begin
         if ($urandom_range(0, 3) != 0)
            press_clear();
         enter_operand();
         repeat ($urandom_range(1, 3)) begin
            press_op(fkc_pkg::op_type'($urandom_range(0, 3)));
            enter_operand();
            if ($urandom_range(0, 9) != 0)
               press_equals();
         end
      end
   endtask

   task automatic await_results();
      push <= 1'b0;
      do @(posedge clock); while (sb.value_q.size() != 0);
   endtask

   initial begin
      int unsigned goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_click(0, 0);
      send_click(21, 21);
      send_click(22, 22);
      send_click(44, 43);
      send_click(65, 65);
      send_click(0, 87);
      send_click(88, 0);
      send_click(0, 88);
      send_click(255, 255);
      send_click(87, 0);
      press_digit(2);
      press_digit(8);
      press_equals();
      press_op(fkc_pkg::OP_SUB);
      press_digit(9);
      press_equals();
      press_op(fkc_pkg::OP_MUL);
      press_digit(4);
      press_equals();
      send_click(87, 87);
      press_digit(1);
      press_equals();
      press_op(fkc_pkg::OP_DIV);
      press_equals();
      press_clear();
      await_results();

      // most negative value over minus one
      press_clear();
      type_value(MOST_NEGATIVE);
      press_op(fkc_pkg::OP_DIV);
      type_value(MINUS_ONE);
      press_equals();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 87;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 87;
            end
            default: begin
               sender_idle_pct = 6;
               receiver_stall_pct = 6;
            end
         endcase
         goal = sb.grid_clicks + CLICK_TARGET / 4;
         while (sb.grid_clicks < goal)
            run_sequence();
         await_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
hdl/fkc_pkg.sv
hdl/fkc_front.sv
hdl/fkc_cmd_queue.sv
hdl/fkc_back.sv
hdl/four_function_keypad_calculator.sv
sim/four_function_keypad_calculator_test.sv
